FILE: rtl/bf_machine_with_xor_unlock_core_assert.svh
// Assertion macros used by the machine's RTL (bfx_exec).
`ifndef BF_MACHINE_WITH_XOR_UNLOCK_CORE_ASSERT_SVH
`define BF_MACHINE_WITH_XOR_UNLOCK_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFX_ASSERT_NOW(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFX_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bfx_pkg.sv
`default_nettype none

package bfx_pkg;

  // Byte memory shared by program and data; the size is a power of two.
  localparam int MEM_ADDR_W = 16;
  localparam int MEM_BYTES  = 1 << MEM_ADDR_W;

  localparam int PC_W        = 17;
  localparam int LOAD_ADDR_W = 16;
  localparam int DEPTH_W     = MEM_ADDR_W + 1;
  localparam int WALK_W      = MEM_ADDR_W + 1;
  // Word count of an unlock walk is reduced modulo MEM_BYTES / 4.
  localparam int WCNT_W      = MEM_ADDR_W - 2;
  localparam int KEY_BYTES   = 8;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  localparam logic [7:0] OP_RIGHT = 8'h3E;  // '>'
  localparam logic [7:0] OP_LEFT  = 8'h3C;  // '<'
  localparam logic [7:0] OP_INC   = 8'h2B;  // '+'
  localparam logic [7:0] OP_DEC   = 8'h2D;  // '-'
  localparam logic [7:0] OP_IN    = 8'h2C;  // ','
  localparam logic [7:0] OP_OUT   = 8'h2E;  // '.'
  localparam logic [7:0] OP_OPEN  = 8'h5B;  // '['
  localparam logic [7:0] OP_CLOSE = 8'h5D;  // ']'
  localparam logic [7:0] OP_KEY   = 8'h3F;  // '?'
  localparam logic [7:0] OP_SIZE  = 8'h23;  // '#'
  localparam logic [7:0] OP_XOR   = 8'h2A;  // '*'

  typedef struct packed {
    logic            ovalid;
    logic [7:0]      obyte;
    logic            iused;
    logic            halted;
    logic [PC_W-1:0] pc;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/bfx_ram.sv
`default_nettype none

module bfx_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] ra_addr,
  output logic      [WIDTH-1:0]         ra_data,
  input  wire logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic      [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/bfx_exec.sv
`default_nettype none

`include "bf_machine_with_xor_unlock_core_assert.svh"

module bfx_exec import bfx_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             in_cmd,
  input  wire logic [LOAD_ADDR_W-1:0] in_addr,
  input  wire logic [7:0]             in_byte,
  input  wire logic                   cfg_wen,
  input  wire logic [PC_W-1:0]        cfg_wdata,
  input  wire logic                   slot_free,
  output logic                        res_push,
  output res_t                        res
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_EXEC  = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_WALK  = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    WK_KEY  = 2'd0,
    WK_SIZE = 2'd1,
    WK_XOR  = 2'd2
  } walk_mode_t;

  state_t                  state;
  logic [PC_W-1:0]         pc;
  logic [MEM_ADDR_W-1:0]   dp;
  logic [63:0]             key;
  logic [63:0]             esize;
  logic [PC_W-1:0]         plen;
  logic [MEM_ADDR_W-1:0]   clr_addr;

  logic [1:0]              cmd_q;
  logic [LOAD_ADDR_W-1:0]  addr_q;
  logic [7:0]              din_q;
  logic                    r_ovalid;
  logic [7:0]              r_obyte;
  logic                    r_iused;

  logic                    sc_fwd;
  logic [PC_W-1:0]         sc_issue;
  logic                    sc_end;
  logic [DEPTH_W-1:0]      depth;
  logic                    pend_v;
  logic [PC_W-1:0]         pend_addr;
  logic [2:0]              pend_idx;
  walk_mode_t              wk_mode;
  logic [MEM_ADDR_W-1:0]   wk_addr;
  logic [WALK_W-1:0]       wk_left;
  logic [2:0]              wk_idx;
  logic [63:0]             wk_word;

  logic                    ram_we;
  logic [MEM_ADDR_W-1:0]   ram_waddr;
  logic [7:0]              ram_wdata;
  logic [MEM_ADDR_W-1:0]   ra_addr;
  logic [7:0]              rd_a;
  logic [7:0]              rd_b;

  logic                    running;
  logic [PC_W-1:0]         pc_inc;
  logic                    depth_up;
  logic                    depth_dn;
  logic [DEPTH_W-1:0]      depth_next;
  logic                    sc_match;
  logic                    sc_exhausted;
  logic [7:0]              key_byte;
  logic [63:0]             wk_word_next;
  logic [WCNT_W-1:0]       wcount;
  logic [WALK_W-1:0]       xor_bytes;

  bfx_ram #(
    .DEPTH (MEM_BYTES),
    .WIDTH (8)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .ra_addr (ra_addr),
    .ra_data (rd_a),
    .rb_addr (dp),
    .rb_data (rd_b)
  );

  // Port A follows the opcode, the bracket scan or the byte walk; port B
  // always reads the cell under the data pointer.
  assign running      = (pc < plen);
  assign pc_inc       = pc + PC_W'(1);
  assign depth_up     = sc_fwd ? (rd_a == OP_OPEN) : (rd_a == OP_CLOSE);
  assign depth_dn     = sc_fwd ? (rd_a == OP_CLOSE) : (rd_a == OP_OPEN);
  assign depth_next   = depth + DEPTH_W'(depth_up) - DEPTH_W'(depth_dn);
  assign sc_match     = pend_v && (depth_next == '0);
  assign sc_exhausted = sc_fwd ? (sc_issue >= plen) : sc_end;
  assign key_byte     = key[{pend_idx, 3'b000} +: 8];
  assign wk_word_next = pend_v ? {rd_a, wk_word[63:8]} : wk_word;
  assign wcount       = esize[3 +: WCNT_W] + WCNT_W'(esize[2:0] != 3'b000);
  assign xor_bytes    = {wcount, 3'b000};

  assign in_ready = (state == ST_IDLE) || ((state == ST_FIN) && slot_free);
  assign res_push = (state == ST_FIN) && slot_free;

  always_comb begin
    res.ovalid = r_ovalid;
    res.obyte  = r_obyte;
    res.iused  = r_iused;
    res.halted = !running;
    res.pc     = pc;
  end

  always_comb begin
    unique case (state)
      ST_SCAN: ra_addr = sc_issue[MEM_ADDR_W-1:0];
      ST_WALK: ra_addr = wk_addr;
      default: ra_addr = pc[MEM_ADDR_W-1:0];
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = dp;
    ram_wdata = 8'h00;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      ST_EXEC: begin
        if (cmd_q == CMD_LOAD) begin
          ram_we    = 1'b1;
          ram_waddr = addr_q[MEM_ADDR_W-1:0];
          ram_wdata = din_q;
        end else if (cmd_q == CMD_STEP && running) begin
          unique case (rd_a)
            OP_INC: begin
              ram_we    = 1'b1;
              ram_wdata = rd_b + 8'd1;
            end
            OP_DEC: begin
              ram_we    = 1'b1;
              ram_wdata = rd_b - 8'd1;
            end
            OP_IN: begin
              ram_we    = 1'b1;
              ram_wdata = din_q;
            end
            default: ram_we = 1'b0;
          endcase
        end
      end
      ST_WALK: begin
        ram_we    = pend_v;
        ram_waddr = pend_addr[MEM_ADDR_W-1:0];
        ram_wdata = (wk_mode == WK_XOR) ? (rd_a ^ key_byte) : 8'h00;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      pc       <= '0;
      dp       <= '0;
      key      <= '0;
      esize    <= '0;
      plen     <= '0;
      clr_addr <= '0;
      pend_v   <= 1'b0;
    end else begin
      if (cfg_wen) begin
        plen <= cfg_wdata;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + MEM_ADDR_W'(1);
          if (&clr_addr) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            cmd_q  <= in_cmd;
            addr_q <= in_addr;
            din_q  <= in_byte;
            state  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          r_ovalid <= 1'b0;
          r_obyte  <= 8'h00;
          r_iused  <= 1'b0;
          pend_v   <= 1'b0;
          state    <= ST_FIN;
          unique case (cmd_q)
            CMD_LOAD: begin
              r_iused <= 1'b0;
            end
            CMD_START: begin
              pc <= '0;
              dp <= plen[MEM_ADDR_W-1:0];
            end
            CMD_STEP: begin
              if (running) begin
                unique case (rd_a)
                  OP_RIGHT: begin
                    dp <= dp + MEM_ADDR_W'(1);
                    pc <= pc_inc;
                  end
                  OP_LEFT: begin
                    dp <= dp - MEM_ADDR_W'(1);
                    pc <= pc_inc;
                  end
                  OP_IN: begin
                    r_iused <= 1'b1;
                    pc      <= pc_inc;
                  end
                  OP_OUT: begin
                    r_ovalid <= 1'b1;
                    r_obyte  <= rd_b;
                    pc       <= pc_inc;
                  end
                  OP_OPEN: begin
                    if (rd_b == 8'h00) begin
                      state    <= ST_SCAN;
                      sc_fwd   <= 1'b1;
                      sc_issue <= pc_inc;
                      sc_end   <= 1'b0;
                      depth    <= DEPTH_W'(1);
                    end else begin
                      pc <= pc_inc;
                    end
                  end
                  OP_CLOSE: begin
                    if (rd_b != 8'h00) begin
                      state    <= ST_SCAN;
                      sc_fwd   <= 1'b0;
                      sc_issue <= pc - PC_W'(1);
                      sc_end   <= (pc == '0);
                      depth    <= DEPTH_W'(1);
                    end else begin
                      pc <= pc_inc;
                    end
                  end
                  OP_KEY, OP_SIZE: begin
                    state   <= ST_WALK;
                    wk_mode <= (rd_a == OP_KEY) ? WK_KEY : WK_SIZE;
                    wk_addr <= pc[MEM_ADDR_W-1:0] + MEM_ADDR_W'(1);
                    wk_left <= WALK_W'(KEY_BYTES);
                    wk_idx  <= 3'd0;
                  end
                  OP_XOR: begin
                    state   <= ST_WALK;
                    wk_mode <= WK_XOR;
                    wk_addr <= pc[MEM_ADDR_W-1:0] + MEM_ADDR_W'(1);
                    wk_left <= xor_bytes;
                    wk_idx  <= 3'd0;
                  end
                  default: begin
                    pc <= pc_inc;
                  end
                endcase
              end
            end
            default: begin
              r_iused <= 1'b0;
            end
          endcase
        end
        ST_SCAN: begin
          // One byte is issued per cycle while the previous one is checked.
          if (pend_v) begin
            depth <= depth_next;
          end
          if (sc_match) begin
            pc     <= pend_addr + PC_W'(1);
            pend_v <= 1'b0;
            state  <= ST_FIN;
          end else if (sc_exhausted) begin
            pc     <= pc_inc;
            pend_v <= 1'b0;
            state  <= ST_FIN;
          end else begin
            pend_v    <= 1'b1;
            pend_addr <= sc_issue;
            if (sc_fwd) begin
              sc_issue <= sc_issue + PC_W'(1);
            end else if (sc_issue == '0) begin
              sc_end <= 1'b1;
            end else begin
              sc_issue <= sc_issue - PC_W'(1);
            end
          end
        end
        ST_WALK: begin
          wk_word <= wk_word_next;
          if (wk_left != '0) begin
            pend_v    <= 1'b1;
            pend_addr <= PC_W'(wk_addr);
            pend_idx  <= wk_idx;
            wk_addr   <= wk_addr + MEM_ADDR_W'(1);
            wk_left   <= wk_left - WALK_W'(1);
            wk_idx    <= wk_idx + 3'd1;
          end else begin
            pend_v <= 1'b0;
            state  <= ST_FIN;
            unique case (wk_mode)
              WK_KEY: begin
                key <= wk_word_next;
                pc  <= pc + PC_W'(KEY_BYTES + 1);
              end
              WK_SIZE: begin
                esize <= wk_word_next;
                pc    <= pc + PC_W'(KEY_BYTES + 1);
              end
              default: begin
                pc <= pc_inc;
              end
            endcase
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            if (in_valid) begin
              cmd_q  <= in_cmd;
              addr_q <= in_addr;
              din_q  <= in_byte;
              state  <= ST_EXEC;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `BFX_ASSERT_NOW(a_scan_no_write, clk, rst, state == ST_SCAN, !ram_we, "memory written during a bracket scan")
  `BFX_ASSERT_NOW(a_clear_blocks, clk, rst, state == ST_CLEAR, !in_ready, "request taken before the clearing pass ended")
  `BFX_ASSERT_NOW(a_fwd_in_range, clk, rst, state == ST_SCAN && sc_fwd && pend_v, pend_addr < plen, "forward scan read past the program")
  `BFX_ASSERT_NOW(a_word_len, clk, rst, state == ST_WALK && wk_mode != WK_XOR, wk_left <= WALK_W'(KEY_BYTES), "key or size load longer than one word")
  `BFX_ASSERT_NEXT(a_accept_exec, clk, rst, in_valid && in_ready, state == ST_EXEC, "accepted request not executed next")
  `BFX_ASSERT_NEXT(a_idle_hold, clk, rst, state == ST_IDLE, $stable(pc) && $stable(dp), "pointers moved while idle")

endmodule

`default_nettype wire

FILE: rtl/bf_machine_with_xor_unlock_core.sv
// Channel   Direction  tdata (lowest bit first)                         tuser
// s_axis    in         load_address[15:0], data_byte[23:16]            cmd[1:0]
// m_axis    out        out_byte[7:0], input_used[8], halted[9],        out_valid
//                      pc_now[26:10], zero[31:27]
// cfg       in         cfg_wdata = program_length (17 bits), cfg_wen strobes it
//
// After reset the byte memory is cleared entry by entry before the first request
// is taken. Loads, starts and simple opcodes pass through states EXEC and FIN,
// since the memory that holds program and data has a registered read.
// A bracket search adds state SCAN; '?' and '#' walk one word of 8 bytes in state WALK,
// and '*' walks 8 bytes per word there, all one byte a cycle through read port A.
// The result sits in an output register, so the next request is taken while it waits.
`default_nettype none

module bf_machine_with_xor_unlock_core import bfx_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [23:0]     s_tdata,   // load_address[15:0], data_byte[23:16]
  input  wire logic [1:0]      s_tuser,   // cmd[1:0]
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic      [31:0]     m_tdata,   // out_byte, input_used, halted, pc_now, pad
  output logic                 m_tuser,   // out_valid
  input  wire logic            cfg_wen,
  input  wire logic [PC_W-1:0] cfg_wdata
);

  logic slot_free;
  logic res_push;
  res_t res;

  assign slot_free = !m_tvalid || m_tready;

  bfx_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (s_tuser),
    .in_addr   (s_tdata[15:0]),
    .in_byte   (s_tdata[23:16]),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .slot_free (slot_free),
    .res_push  (res_push),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      m_tdata <= {5'b00000, res.pc, res.halted, res.iused, res.obyte};
      m_tuser <= res.ovalid;
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/bfx_step_checker.sv
`default_nettype none

module bfx_step_checker import bfx_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  input  wire logic            s_tready,
  input  wire logic [23:0]     s_tdata,
  input  wire logic [1:0]      s_tuser,
  input  wire logic            m_tvalid,
  input  wire logic            m_tready,
  input  wire logic [31:0]     m_tdata,
  input  wire logic            m_tuser,
  input  wire logic            cfg_wen,
  input  wire logic [PC_W-1:0] cfg_wdata,
  output int                   mismatches,
  output int                   outstanding
);

  logic [7:0]            mem_img [MEM_BYTES];
  logic [PC_W-1:0]       pc_q;
  logic [PC_W-1:0]       prog_len;
  logic [MEM_ADDR_W-1:0] dptr;
  logic [63:0]           key_q;
  logic [63:0]           size_q;
  res_t                  awaited [$];

  function automatic logic [63:0] word_at(input logic [MEM_ADDR_W-1:0] base);
    logic [63:0]           v;
    logic [MEM_ADDR_W-1:0] a;
    v = '0;
    for (int k = 0; k < KEY_BYTES; k++) begin
      a = base + MEM_ADDR_W'(k);
      v[8*k +: 8] = mem_img[a];
    end
    return v;
  endfunction

  task automatic put_word(input logic [MEM_ADDR_W-1:0] base, input logic [63:0] v);
    logic [MEM_ADDR_W-1:0] a;
    for (int k = 0; k < KEY_BYTES; k++) begin
      a = base + MEM_ADDR_W'(k);
      mem_img[a] = v[8*k +: 8];
    end
  endtask

  task automatic execute_op(input logic [7:0] din, output logic ov, output logic [7:0] ob,
                            output logic iu);
    logic [7:0]            op;
    logic [7:0]            c;
    logic [MEM_ADDR_W-1:0] dp;
    logic [MEM_ADDR_W-1:0] a;
    int unsigned           pc;
    int                    i;
    int                    depth;
    longint unsigned       words;
    longint unsigned       j;
    ov = 1'b0;
    ob = 8'd0;
    iu = 1'b0;
    pc = pc_q;
    op = mem_img[pc[MEM_ADDR_W-1:0]];
    dp = dptr;
    case (op)
      OP_RIGHT: dptr = dp + 1'b1;
      OP_LEFT:  dptr = dp - 1'b1;
      OP_INC:   mem_img[dp] = mem_img[dp] + 8'd1;
      OP_DEC:   mem_img[dp] = mem_img[dp] - 8'd1;
      OP_IN: begin
        mem_img[dp] = din;
        iu = 1'b1;
      end
      OP_OUT: begin
        ov = 1'b1;
        ob = mem_img[dp];
      end
      OP_OPEN: if (mem_img[dp] == 8'd0) begin
        // The forward search stops at the end of the program; if no partner
        // is found the counter simply moves on.
        depth = 0;
        for (i = pc; i < int'(prog_len); i++) begin
          c = mem_img[i[MEM_ADDR_W-1:0]];
          if (c == OP_CLOSE) depth--;
          if (c == OP_OPEN) depth++;
          if (depth == 0) begin
            pc = i;
            break;
          end
        end
      end
      OP_CLOSE: if (mem_img[dp] != 8'd0) begin
        depth = 0;
        i = pc;
        forever begin
          c = mem_img[i[MEM_ADDR_W-1:0]];
          if (c == OP_OPEN) depth--;
          if (c == OP_CLOSE) depth++;
          if (depth == 0) begin
            pc = i;
            break;
          end
          if (i == 0) break;
          i--;
        end
      end
      OP_KEY: begin
        a = MEM_ADDR_W'(pc + 1);
        key_q = word_at(a);
        put_word(a, '0);
        pc += KEY_BYTES;
      end
      OP_SIZE: begin
        a = MEM_ADDR_W'(pc + 1);
        size_q = word_at(a);
        put_word(a, '0);
        pc += KEY_BYTES;
      end
      OP_XOR: begin
        // A word walk repeats after MEM_BYTES/8 words and two passes cancel,
        // so only the count modulo MEM_BYTES/4 matters.
        words = (size_q >> 3) + (size_q[2:0] != 3'd0);
        words = words % (MEM_BYTES / 4);
        for (j = 0; j < words; j++) begin
          a = MEM_ADDR_W'(pc + 1 + 8 * j);
          put_word(a, word_at(a) ^ key_q);
        end
      end
      default: ;
    endcase
    pc_q = PC_W'(pc + 1);
  endtask

  task automatic predict(input logic [1:0] cmd, input logic [15:0] addr, input logic [7:0] din,
                         output res_t r);
    r = '0;
    case (cmd)
      CMD_LOAD:  mem_img[addr] = din;
      CMD_START: begin
        pc_q = '0;
        dptr = prog_len[MEM_ADDR_W-1:0];
      end
      CMD_STEP:  if (pc_q < prog_len) execute_op(din, r.ovalid, r.obyte, r.iused);
      default: ;
    endcase
    r.halted = (pc_q >= prog_len);
    r.pc = pc_q;
  endtask

  always @(posedge clk) begin
    res_t want;
    res_t got;
    res_t fresh;
    if (rst) begin
      foreach (mem_img[a]) mem_img[a] = 8'd0;
      pc_q = '0;
      prog_len = '0;
      dptr = '0;
      key_q = '0;
      size_q = '0;
      awaited.delete();
      mismatches = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.ovalid = m_tuser;
        got.obyte = m_tdata[7:0];
        got.iused = m_tdata[8];
        got.halted = m_tdata[9];
        got.pc = m_tdata[26:10];
        if (awaited.size() == 0) begin
          $display("%0t: result with no request outstanding: out_valid=%b byte=%h used=%b halted=%b pc=%h",
                   $time, got.ovalid, got.obyte, got.iused, got.halted, got.pc);
          mismatches++;
        end else begin
          want = awaited.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch: expected out_valid=%b byte=%h used=%b halted=%b pc=%h",
                     $time, want.ovalid, want.obyte, want.iused, want.halted, want.pc);
            $display("%0t:                  actual out_valid=%b byte=%h used=%b halted=%b pc=%h",
                     $time, got.ovalid, got.obyte, got.iused, got.halted, got.pc);
            mismatches++;
          end
        end
        if (m_tdata[31:27] !== 5'd0) begin
          $display("%0t: tdata padding expected 00 actual %h", $time, m_tdata[31:27]);
          mismatches++;
        end
      end
      if (cfg_wen) prog_len = cfg_wdata;
      if (s_tvalid && s_tready) begin
        predict(s_tuser, s_tdata[15:0], s_tdata[23:16], fresh);
        awaited.push_back(fresh);
      end
    end
    outstanding = awaited.size();
  end

endmodule

`default_nettype wire

FILE: tb/sv/bf_machine_with_xor_unlock_core_test.sv
`default_nettype none

module bf_machine_with_xor_unlock_core_test;
  import bfx_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 600000;
  localparam int ITEM_TARGET = 800;

  logic            clk;
  logic            rst = 1'b1;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [23:0]     s_tdata = '0;   // load_address[15:0], data_byte[23:16]
  logic [1:0]      s_tuser = CMD_LOAD;  // cmd[1:0]
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [31:0]     m_tdata;        // out_byte, input_used, halted, pc_now, zero padding
  logic            m_tuser;        // out_valid
  logic            cfg_wen = 1'b0;
  logic [PC_W-1:0] cfg_wdata = '0;

  int errors;
  int in_flight;
  int gap_pct = 0;
  int stall_pct = 0;
  int issued = 0;

  bf_machine_with_xor_unlock_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  bfx_step_checker watch (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .mismatches (errors),
    .outstanding(in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // A long '*' walk can hold the core busy while no request is taken.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Entered and left at a falling edge; valid stays high if the next request follows.
  task automatic push_request(input logic [1:0] cmd, input logic [15:0] addr,
                              input logic [7:0] data);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {data, addr};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (cmd != CMD_UNUSED) issued++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (in_flight != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_length(input logic [PC_W-1:0] len);
    drain();
    cfg_wen <= 1'b1;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic run_program();
    logic [7:0]      code [$];
    logic [PC_W-1:0] len;
    int              target;
    int              depth;
    int              r;
    int              steps;
    target = $urandom_range(3, 40);
    depth = 0;
    while (code.size() < target) begin
      r = $urandom_range(99);
      if (r < 14) code.push_back(OP_INC);
      else if (r < 26) code.push_back(OP_DEC);
      else if (r < 38) code.push_back(OP_RIGHT);
      else if (r < 48) code.push_back(OP_LEFT);
      else if (r < 58) code.push_back(OP_IN);
      else if (r < 70) code.push_back(OP_OUT);
      else if (r < 80) begin
        code.push_back(OP_OPEN);
        depth++;
      end else if (r < 90) begin
        // With nothing open this is an unmatched close.
        code.push_back(OP_CLOSE);
        if (depth > 0) depth--;
      end else if (r < 93) begin
        code.push_back(OP_KEY);
        repeat (KEY_BYTES) code.push_back(8'($urandom));
      end else if (r < 96) begin
        code.push_back(OP_SIZE);
        if ($urandom_range(7) == 0) begin
          // All ones reduces to no words at all.
          repeat (KEY_BYTES) code.push_back(8'hFF);
        end else begin
          // Keep bits 3 to 16 small so that the walk stays short; the upper
          // bits vanish in the modulo reduction.
          code.push_back(8'($urandom));
          code.push_back(8'($urandom_range(0, 1)));
          code.push_back(8'($urandom) & 8'hFE);
          repeat (KEY_BYTES - 3) code.push_back(8'($urandom));
        end
      end else if (r < 98) code.push_back(OP_XOR);
      else code.push_back(8'($urandom));
    end
    if ($urandom_range(5) != 0) repeat (depth) code.push_back(OP_CLOSE);

    len = PC_W'(code.size());
    if ($urandom_range(9) == 0) len = len + PC_W'($urandom_range(1, 6));
    set_length(len);
    foreach (code[k]) push_request(CMD_LOAD, 16'(k), code[k]);
    repeat ($urandom_range(0, 4))
      push_request(CMD_LOAD, 16'(len + PC_W'($urandom_range(0, 3))), 8'($urandom));
    push_request(CMD_START, 16'($urandom), 8'($urandom));

    steps = 2 * len + 8;
    repeat (steps) begin
      r = $urandom_range(99);
      if (r < 2) push_request(CMD_UNUSED, 16'($urandom), 8'($urandom));
      else if (r < 4) push_request(CMD_LOAD, 16'($urandom), 8'($urandom));
      else if (r < 5) push_request(CMD_START, 16'($urandom), 8'($urandom));
      else push_request(CMD_STEP, 16'($urandom), 8'($urandom));
    end
  endtask

  initial begin : stimulus
    int phase;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Length zero after reset: every step is halted, and cmd 3 only reports status.
    push_request(CMD_STEP, 16'h0000, 8'h00);
    push_request(CMD_UNUSED, 16'hFFFF, 8'hFF);
    push_request(CMD_LOAD, 16'hFFFF, 8'hFF);
    push_request(CMD_START, 16'h0000, 8'h00);
    push_request(CMD_STEP, 16'h0000, 8'h00);

    // Data pointer starts at the top byte and wraps both ways; the close
    // then searches back to a bracket at address zero.
    set_length(17'h0FFFF);
    push_request(CMD_LOAD, 16'd0, OP_OPEN);
    push_request(CMD_LOAD, 16'd1, OP_OUT);
    push_request(CMD_LOAD, 16'd2, OP_INC);
    push_request(CMD_LOAD, 16'd3, OP_RIGHT);
    push_request(CMD_LOAD, 16'd4, OP_LEFT);
    push_request(CMD_LOAD, 16'd5, OP_IN);
    push_request(CMD_LOAD, 16'd6, OP_CLOSE);
    push_request(CMD_START, 16'h0000, 8'h00);
    repeat (8) push_request(CMD_STEP, 16'h0000, 8'hA5);

    // Length of the whole memory: the data pointer wraps to zero, over the program itself.
    set_length(17'h10000);
    push_request(CMD_START, 16'h0000, 8'h00);
    repeat (2) push_request(CMD_STEP, 16'h0000, 8'h00);

    phase = 0;
    while (issued < ITEM_TARGET) begin
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 86; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 86; end
        default: begin gap_pct = 31; stall_pct = 31; end
      endcase
      run_program();
      phase++;
    end

    drain();
    repeat (16) @(negedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/bfx_pkg.sv
rtl/bfx_ram.sv
rtl/bfx_exec.sv
rtl/bf_machine_with_xor_unlock_core.sv
tb/sv/bfx_step_checker.sv
tb/sv/bf_machine_with_xor_unlock_core_test.sv
